>>> rtl/sce_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the spring chain Euler step block.
// Depends on nothing; every other file imports it.
package sce_pkg;

    localparam int WORD_W      = 32;
    localparam int COEF_W      = 16;
    localparam int CFG_INDEX_W = 2;

    // Work queue between the front and back ends; depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration register indexes and reset values.
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP = 2'd1;
    localparam logic [COEF_W-1:0] GAIN_RESET = 16'd262;
    localparam logic [COEF_W-1:0] STEP_RESET = 16'd1311;

    // What the first result of a queued job is.
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_EDGE     = 2'd1;
    localparam logic [1:0] KIND_INTERIOR = 2'd2;

    typedef struct packed {
        logic signed [WORD_W-1:0] position;
        logic signed [WORD_W-1:0] velocity;
        logic                     chain_end;
    } mass_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] new_position;
        logic signed [WORD_W-1:0] new_velocity;
        logic                     last_of_chain;
        logic                     saturated;
    } result_t;

    typedef struct packed {
        logic [COEF_W-1:0] velocity_gain;
        logic [COEF_W-1:0] time_step;
    } cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] older;
        logic signed [WORD_W-1:0] held;
        logic signed [WORD_W-1:0] held_velocity;
        logic signed [WORD_W-1:0] position;
        logic [1:0]               kind;
        logic                     second_end;
    } work_t;

endpackage

>>> rtl/sce_front.sv
`timescale 1ns / 1ps
// Front end: takes mass words, keeps the two-deep position delay line and
// turns each word into a job for the work queue. Depends on sce_pkg.
module sce_front
    import sce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  mass_t item,
    input  logic  item_valid,
    output logic  item_stall,
    input  logic  queue_full,
    output logic  push,
    output work_t work
);

    localparam logic [1:0] MS_START    = 2'd0;
    localparam logic [1:0] MS_FIRST    = 2'd1;
    localparam logic [1:0] MS_INTERIOR = 2'd2;

    logic [1:0]               seen_reg, seen_next;
    logic signed [WORD_W-1:0] older_reg, older_next;
    logic signed [WORD_W-1:0] held_pos_reg, held_pos_next;
    logic signed [WORD_W-1:0] held_vel_reg, held_vel_next;
    logic                     accept;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;

    always_comb
    begin
        seen_next       = seen_reg;
        older_next      = older_reg;
        held_pos_next   = held_pos_reg;
        held_vel_next   = held_vel_reg;
        push            = 1'b0;
        work.older         = older_reg;
        work.held          = held_pos_reg;
        work.held_velocity = held_vel_reg;
        work.position      = item.position;
        work.kind          = KIND_NONE;
        work.second_end    = item.chain_end;
        if (accept)
        begin
            case (seen_reg)
                MS_START:
                begin
                    if (item.chain_end)
                    begin
                        // A chain of one mass goes out at once.
                        push = 1'b1;
                    end
                    else
                    begin
                        held_pos_next = item.position;
                        held_vel_next = item.velocity;
                        seen_next     = MS_FIRST;
                    end
                end
                default:
                begin
                    push      = 1'b1;
                    work.kind = (seen_reg == MS_FIRST) ? KIND_EDGE : KIND_INTERIOR;
                    if (item.chain_end)
                    begin
                        seen_next = MS_START;
                    end
                    else
                    begin
                        older_next    = held_pos_reg;
                        held_pos_next = item.position;
                        held_vel_next = item.velocity;
                        seen_next     = MS_INTERIOR;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= MS_START;
            older_reg    <= '0;
            held_pos_reg <= '0;
            held_vel_reg <= '0;
        end
        else
        begin
            seen_reg     <= seen_next;
            older_reg    <= older_next;
            held_pos_reg <= held_pos_next;
            held_vel_reg <= held_vel_next;
        end
    end

endmodule

>>> rtl/sce_queue.sv
`timescale 1ns / 1ps
// Short job queue that decouples the front end from the back end.
// Depends on sce_pkg for the job type and depth.
module sce_queue
    import sce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    input  logic  pop,
    output work_t pop_data,
    output logic  full,
    output logic  empty
);

    work_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/sce_back.sv
`timescale 1ns / 1ps
// Back end: runs queued jobs through one shared multiplier and a saturating
// adder, and holds the output word register. Depends on sce_pkg.
module sce_back
    import sce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  work_t   head,
    input  logic    queue_empty,
    output logic    pop,
    output result_t result,
    output logic    result_valid,
    input  logic    result_stall
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LAP  = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_ADD1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_ADD2 = 3'd5;
    localparam logic [2:0] S_OUT1 = 3'd6;
    localparam logic [2:0] S_OUT2 = 3'd7;

    localparam int LAP_W  = WORD_W + 2;
    localparam int PROD_W = LAP_W + COEF_W + 1;
    localparam int SHR_W  = PROD_W - COEF_W;
    localparam int SUM_W  = SHR_W + 1;

    logic [2:0]               state_reg, state_next;
    work_t                    work_reg, work_next;
    logic signed [LAP_W-1:0]  lap_reg, lap_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [WORD_W-1:0] vel_reg, vel_next;
    logic                     sat_reg, sat_next;
    result_t                  res_reg, res_next;
    result_t                  out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic signed [LAP_W-1:0]  lap_calc;
    logic signed [LAP_W-1:0]  mul_a;
    logic [COEF_W-1:0]        mul_coef;
    logic signed [PROD_W-1:0] prod_calc;
    logic signed [PROD_W-1:0] rounded;
    logic signed [SHR_W-1:0]  shifted;
    logic signed [WORD_W-1:0] add_base;
    logic signed [SUM_W-1:0]  sum_calc;
    logic signed [WORD_W-1:0] clamp_value;
    logic                     clamp_flag;
    logic                     can_load;

    assign result       = out_reg;
    assign result_valid = out_valid_reg;
    assign can_load     = !out_valid_reg || !result_stall;

    // Three-point Laplacian of the held mass, exact in 34 bits.
    assign lap_calc = {{2{work_reg.older[WORD_W-1]}}, work_reg.older}
                    - {work_reg.held[WORD_W-1], work_reg.held, 1'b0}
                    + {{2{work_reg.position[WORD_W-1]}}, work_reg.position};

    assign mul_a     = (state_reg == S_MUL1) ? lap_reg
                                             : {{2{vel_reg[WORD_W-1]}}, vel_reg};
    assign mul_coef  = (state_reg == S_MUL1) ? cfg.velocity_gain : cfg.time_step;
    assign prod_calc = mul_a * $signed({1'b0, mul_coef});

    // Round to nearest with ties upward: add half, then floor shift.
    assign rounded  = prod_reg + (PROD_W)'(32'sd1 <<< (COEF_W - 1));
    assign shifted  = rounded[PROD_W-1:COEF_W];
    assign add_base = (state_reg == S_ADD1) ? work_reg.held_velocity : work_reg.held;
    assign sum_calc = {{(SUM_W - WORD_W){add_base[WORD_W-1]}}, add_base}
                    + {shifted[SHR_W-1], shifted};

    always_comb
    begin
        clamp_flag  = 1'b0;
        clamp_value = sum_calc[WORD_W-1:0];
        if (sum_calc[SUM_W-1] && !(&sum_calc[SUM_W-2:WORD_W-1]))
        begin
            clamp_flag  = 1'b1;
            clamp_value = {1'b1, {(WORD_W - 1){1'b0}}};
        end
        else if (!sum_calc[SUM_W-1] && (|sum_calc[SUM_W-2:WORD_W-1]))
        begin
            clamp_flag  = 1'b1;
            clamp_value = {1'b0, {(WORD_W - 1){1'b1}}};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        lap_next       = lap_reg;
        prod_next      = prod_reg;
        vel_next       = vel_reg;
        sat_next       = sat_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        pop            = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop       = 1'b1;
                    work_next = head;
                    case (head.kind)
                        KIND_INTERIOR:
                        begin
                            state_next = S_LAP;
                        end
                        KIND_EDGE:
                        begin
                            res_next.new_position  = head.held;
                            res_next.new_velocity  = '0;
                            res_next.last_of_chain = 1'b0;
                            res_next.saturated     = 1'b0;
                            state_next             = S_OUT1;
                        end
                        default:
                        begin
                            state_next = S_OUT2;
                        end
                    endcase
                end
            end
            S_LAP:
            begin
                lap_next   = lap_calc;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                prod_next  = prod_calc;
                state_next = S_ADD1;
            end
            S_ADD1:
            begin
                vel_next   = clamp_value;
                sat_next   = clamp_flag;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                prod_next  = prod_calc;
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                res_next.new_position  = clamp_value;
                res_next.new_velocity  = vel_reg;
                res_next.last_of_chain = 1'b0;
                res_next.saturated     = sat_reg || clamp_flag;
                state_next             = S_OUT1;
            end
            S_OUT1:
            begin
                if (can_load)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = work_reg.second_end ? S_OUT2 : S_IDLE;
                end
            end
            S_OUT2:
            begin
                if (can_load)
                begin
                    // The last mass of a chain keeps its place and stops.
                    out_next.new_position  = work_reg.position;
                    out_next.new_velocity  = '0;
                    out_next.last_of_chain = 1'b1;
                    out_next.saturated     = 1'b0;
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        lap_reg  <= lap_next;
        prod_reg <= prod_next;
        vel_reg  <= vel_next;
        sat_reg  <= sat_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/spring_chain_euler_step.sv
`timescale 1ns / 1ps
// Top level of the spring chain Euler step: configuration registers and the
// front end, work queue and back end. Depends on sce_pkg and the sce_ modules.
//
//   channel   signals                               word
//   item      item_valid, item_stall, item          mass_t
//   result    result_valid, result_stall, result    result_t
//   cfg       cfg_valid, cfg_ready, cfg_index       cfg_data (16 bits)
//
// In the back end an interior mass goes through taking the job, the Laplacian,
// two multiply and saturate passes through the single shared multiplier, and
// loading the output register. An end mass goes from taking the job straight
// to the output load, and the word that closes a chain adds a second load.
// The front end takes a word each cycle until the two-entry work queue is full.
// Reset clears the delay line state, the queue, the output valid and sets
// the coefficients to their defaults. A stalled result holds the back end.
module spring_chain_euler_step
    import sce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mass_t                  item,
    input  logic                   item_valid,
    output logic                   item_stall,
    output result_t                result,
    output logic                   result_valid,
    input  logic                   result_stall,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]      cfg_data
);

    cfg_t  cfg_reg;
    work_t push_work;
    work_t head_work;
    logic  push;
    logic  pop;
    logic  queue_full;
    logic  queue_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.velocity_gain <= GAIN_RESET;
            cfg_reg.time_step     <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAIN: cfg_reg.velocity_gain <= cfg_data;
                CFG_STEP: cfg_reg.time_step     <= cfg_data;
                default:  cfg_reg <= cfg_reg;
            endcase
        end
    end

    sce_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .queue_full (queue_full),
        .push       (push),
        .work       (push_work)
    );

    sce_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_work),
        .pop       (pop),
        .pop_data  (head_work),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    sce_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head_work),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

>>> tb/sce_step_checker.sv
`timescale 1ns / 1ps
// Checker for the spring chain Euler step: watches the item, result and cfg channels,
// predicts every stepped mass and compares it with what the block returns.
// Depends on sce_pkg for the word types and the register indexes.
module sce_step_checker
    import sce_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mass_t                  item,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  result_t                result,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]      cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     checked
);

    typedef enum logic [1:0] {
        CHAIN_START,
        FIRST_HELD,
        INTERIOR_HELD
    } chain_phase_e;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483647 - 64'sd1;

    logic [COEF_W-1:0]        gain_coef = GAIN_RESET;
    logic [COEF_W-1:0]        dt_coef = STEP_RESET;
    logic signed [WORD_W-1:0] prev_pos = '0;
    logic signed [WORD_W-1:0] held_pos = '0;
    logic signed [WORD_W-1:0] held_vel = '0;
    chain_phase_e             chain_phase = CHAIN_START;
    result_t                  stepped_masses[$];
    int                       fails = 0;
    int                       seen = 0;

    // Signed value times a Q0.16 coefficient, rounded to nearest with ties upward.
    function automatic longint scale_q16(longint a, logic [COEF_W-1:0] coef);
        longint prod;
        prod = a * $signed({48'd0, coef}) + 64'sd32768;
        return prod >>> COEF_W;
    endfunction

    function automatic longint clamp_word(longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    function automatic result_t end_mass(logic signed [WORD_W-1:0] pos, logic last);
        result_t r;
        r.new_position = pos;
        r.new_velocity = '0;
        r.last_of_chain = last;
        r.saturated = 1'b0;
        return r;
    endfunction

    function automatic void advance_chain(mass_t m);
        longint  lap;
        longint  vn;
        longint  xn;
        logic    sat;
        result_t r;
        if (chain_phase == CHAIN_START)
        begin
            if (m.chain_end)
                stepped_masses.push_back(end_mass(m.position, 1'b1));
            else
            begin
                held_pos = m.position;
                held_vel = m.velocity;
                chain_phase = FIRST_HELD;
            end
            return;
        end
        if (chain_phase == FIRST_HELD)
            stepped_masses.push_back(end_mass(held_pos, 1'b0));
        else
        begin
            lap = longint'(prev_pos) - 2 * longint'(held_pos)
                + longint'($signed(m.position));
            vn = longint'(held_vel) + scale_q16(lap, gain_coef);
            sat = (vn > WORD_MAX) || (vn < WORD_MIN);
            vn = clamp_word(vn);
            xn = longint'(held_pos) + scale_q16(vn, dt_coef);
            sat = sat || (xn > WORD_MAX) || (xn < WORD_MIN);
            xn = clamp_word(xn);
            r.new_position = xn[WORD_W-1:0];
            r.new_velocity = vn[WORD_W-1:0];
            r.last_of_chain = 1'b0;
            r.saturated = sat;
            stepped_masses.push_back(r);
        end
        if (m.chain_end)
        begin
            // The closing word also flushes itself as the far end mass.
            stepped_masses.push_back(end_mass(m.position, 1'b1));
            chain_phase = CHAIN_START;
        end
        else
        begin
            prev_pos = held_pos;
            held_pos = m.position;
            held_vel = m.velocity;
            chain_phase = INTERIOR_HELD;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            gain_coef = GAIN_RESET;
            dt_coef = STEP_RESET;
            prev_pos = '0;
            held_pos = '0;
            held_vel = '0;
            chain_phase = CHAIN_START;
            stepped_masses.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAIN: gain_coef = cfg_data;
                    CFG_STEP: dt_coef = cfg_data;
                    default: ;
                endcase
            end
            // Predict first so a word and its result on the same edge still line up.
            if (item_valid && !item_stall)
                advance_chain(item);
            if (result_valid && !result_stall)
            begin
                seen++;
                if (stepped_masses.size() == 0)
                begin
                    if (fails < 10)
                        $display("%0t: result word with nothing expected: %s %0d %0d %0b %0b",
                                 $time, "pos vel last sat", result.new_position,
                                 result.new_velocity, result.last_of_chain,
                                 result.saturated);
                    fails++;
                end
                else
                begin
                    want = stepped_masses.pop_front();
                    if (result.new_position !== want.new_position
                        || result.new_velocity !== want.new_velocity
                        || result.last_of_chain !== want.last_of_chain
                        || result.saturated !== want.saturated)
                    begin
                        if (fails < 10)
                        begin
                            $display("%0t: mismatch, expected pos %0d vel %0d last %0b sat %0b",
                                     $time, want.new_position, want.new_velocity,
                                     want.last_of_chain, want.saturated);
                            $display("%0t:           got      pos %0d vel %0d last %0b sat %0b",
                                     $time, result.new_position, result.new_velocity,
                                     result.last_of_chain, result.saturated);
                        end
                        fails++;
                    end
                end
            end
        end
        fail_count <= fails;
        pending <= stepped_masses.size();
        checked <= seen;
    end

endmodule

>>> tb/spring_chain_euler_step_tb.sv
`timescale 1ns / 1ps
// Testbench top for the spring chain Euler step: clock, reset, mass and register
// stimulus, receiver stalls and the verdict. Depends on sce_pkg and sce_step_checker.
module spring_chain_euler_step_tb;
    import sce_pkg::*;

    localparam logic signed [WORD_W-1:0] WMAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WMIN = 32'sh8000_0000;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int NUM_PHASES = 8;
    localparam int MASSES_PER_PHASE = 240;
    localparam int SETTLE_CYCLES = 32;

    logic                   clk;
    logic                   rst_n;
    mass_t                  item;
    logic                   item_valid;
    logic                   item_stall;
    result_t                result;
    logic                   result_valid;
    logic                   result_stall;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COEF_W-1:0]      cfg_data;
    int                     fail_count;
    int                     pending;
    int                     checked;

    int masses_sent = 0;
    int chains_sent = 0;
    int settings_used = 0;
    int burst_left = 0;

    spring_chain_euler_step i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    sce_step_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // The receiver switches between random stall patterns, holding each for a random stretch.
    initial
    begin
        int mode;
        int left;
        result_stall = 1'b0;
        left = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 3) != 0);
                default: result_stall <= ((left / 8) % 2 == 1);
            endcase
        end
    end

    // Sends one mass word; the sender runs in bursts separated by random gaps.
    task automatic send_mass(input mass_t m);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        item <= m;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        masses_sent++;
    endtask

    // Stops sending and waits until every stepped mass has come back.
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [WORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return WMIN;
            1: return WMAX;
            2: return '0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    // One chain with a random flavor: smooth springs, full range words,
    // extreme values or wide swings.
    task automatic run_chain(input int len);
        int    mode;
        int    base;
        mass_t m;
        mode = $urandom_range(0, 5);
        base = int'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
        for (int k = 0; k < len; k++)
        begin
            case (mode)
                0, 1:
                begin
                    m.position = base + int'($urandom_range(0, 8191)) - 4096;
                    m.velocity = int'($urandom_range(0, 131071)) - 65536;
                end
                2:
                begin
                    m.position = $urandom;
                    m.velocity = $urandom;
                end
                3:
                begin
                    m.position = pick_extreme();
                    m.velocity = pick_extreme();
                end
                default:
                begin
                    m.position = int'($urandom) >>> 1;
                    m.velocity = int'($urandom) >>> 2;
                end
            endcase
            m.chain_end = (k == len - 1);
            send_mass(m);
        end
        chains_sent++;
    endtask

    initial
    begin
        logic [COEF_W-1:0] g;
        logic [COEF_W-1:0] s;
        int                phase_masses;
        int                len;
        int                pick;
        rst_n = 1'b0;
        item = '0;
        item_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GAIN;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset coefficients: a one-mass chain, a two-mass chain, a short interior.
        settings_used++;
        send_mass(mass_t'{WMAX, WMIN, 1'b1});
        send_mass(mass_t'{WMIN, WMAX, 1'b0});
        send_mass(mass_t'{WMAX, WMIN, 1'b1});
        send_mass(mass_t'{32'sh0001_0000, 32'sh0000_8000, 1'b0});
        send_mass(mass_t'{-32'sh0002_0000, 32'sh0, 1'b0});
        send_mass(mass_t'{32'sh0003_0000, -32'sh0001_0000, 1'b0});
        send_mass(mass_t'{32'sh0, 32'sh1234_5678, 1'b1});
        chains_sent += 3;
        drain();

        // Largest coefficients with alternating extremes drive both clamps.
        write_reg(CFG_GAIN, 16'hFFFF);
        write_reg(CFG_STEP, 16'hFFFF);
        settings_used++;
        for (int k = 0; k < 6; k++)
            send_mass(mass_t'{(k % 2) ? WMAX : WMIN, (k % 2) ? WMIN : WMAX, k == 5});
        chains_sent++;
        drain();

        // Writes to the spare indexes must leave both coefficients alone.
        write_reg(CFG_SPARE_A, 16'h0000);
        write_reg(CFG_SPARE_B, 16'h0001);
        send_mass(mass_t'{WMIN, WMAX, 1'b0});
        send_mass(mass_t'{WMAX, WMAX, 1'b0});
        send_mass(mass_t'{WMIN, WMIN, 1'b1});
        chains_sent++;
        drain();
        write_reg(CFG_GAIN, 16'h0000);
        write_reg(CFG_STEP, 16'h0000);
        settings_used++;
        send_mass(mass_t'{-32'sd1, -32'sd1, 1'b0});
        send_mass(mass_t'{32'sd1, 32'sd1, 1'b0});
        send_mass(mass_t'{-32'sd1, WMAX, 1'b0});
        send_mass(mass_t'{32'sd1, WMIN, 1'b1});
        chains_sent++;
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    g = GAIN_RESET;
                    s = STEP_RESET;
                end
                1:
                begin
                    g = 16'hFFFF;
                    s = 16'h0000;
                end
                2:
                begin
                    g = 16'h0000;
                    s = 16'hFFFF;
                end
                3:
                begin
                    g = 16'hFFFF;
                    s = 16'hFFFF;
                end
                4:
                begin
                    g = COEF_W'($urandom_range(1, 15));
                    s = COEF_W'($urandom_range(1, 15));
                end
                default:
                begin
                    g = COEF_W'($urandom);
                    s = COEF_W'($urandom);
                end
            endcase
            write_reg(CFG_GAIN, g);
            if (ph == 5)
                write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B,
                          COEF_W'($urandom));
            write_reg(CFG_STEP, s);
            settings_used++;

            phase_masses = 0;
            while (phase_masses < MASSES_PER_PHASE)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    len = 1;
                else if (pick == 1)
                    len = 2;
                else if (pick == 2)
                    len = $urandom_range(20, 60);
                else
                    len = $urandom_range(3, 12);
                run_chain(len);
                phase_masses += len;
                // Now and then the sender holds off until the block has emptied.
                if ($urandom_range(0, 24) == 0)
                    drain();
            end
            drain();
        end

        $display("Sent %0d masses in %0d chains under %0d coefficient settings.",
                 masses_sent, chains_sent, settings_used);
        $display("Checked %0d stepped masses, %0d failures.", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sce_pkg.sv
rtl/sce_front.sv
rtl/sce_queue.sv
rtl/sce_back.sv
rtl/spring_chain_euler_step.sv
tb/sce_step_checker.sv
tb/spring_chain_euler_step_tb.sv
